FILE: rtl/core/ilcc_pkg.sv
// Package for the interface length crossing counter.
// Holds field widths, sign codes, register indexes, fixed-point constants and shared types.
// No dependencies.
package ilcc_pkg;

  localparam int unsigned DEF_MAX_SIDE    = 1024;
  localparam int unsigned DEF_SAMPLE_BITS = 16;

  localparam int unsigned SIZE_W    = 11;
  localparam int unsigned SPACING_W = 21;
  localparam int unsigned COUNT_W   = 20;
  localparam int unsigned LEN_W     = 44;
  localparam int unsigned SUM_W     = COUNT_W + 1;

  localparam logic [SIZE_W-1:0]    GRID_SIZE_RST    = SIZE_W'(256);
  localparam logic [SPACING_W-1:0] GRID_SPACING_RST = SPACING_W'(65536);

  // sqrt(2) in Q30 and pi/8 in Q32.
  localparam int unsigned CONST_W = 31;
  localparam logic [CONST_W-1:0] SQRT2_Q30 = 31'd1518500250;
  localparam logic [CONST_W-1:0] PI8_Q32   = 31'd1686629713;

  // Length datapath widths: T below 2^53, K below 2^36, product below 2^89.
  localparam int unsigned T_W      = 53;
  localparam int unsigned KPROD_W  = CONST_W + SPACING_W;
  localparam int unsigned K_W      = 36;
  localparam int unsigned K_SHIFT  = 16;
  localparam int unsigned T_LO_W   = 27;
  localparam int unsigned K_LO_W   = 18;
  localparam int unsigned PP_W     = T_LO_W + K_LO_W;
  localparam int unsigned ACC_W    = 90;
  localparam int unsigned LEN_SHIFT = 46;

  localparam int unsigned OUT_DATA_W = 128;

  // Configuration register indexes (word address bit).
  typedef enum logic {
    REG_GRID_SIZE    = 1'b0,
    REG_GRID_SPACING = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    SIGN_ZERO = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } sign_e;

  typedef enum logic [2:0] {
    LU_IDLE,
    LU_PREP,
    LU_SUM,
    LU_MUL,
    LU_ADD,
    LU_DONE
  } lu_state_e;

  typedef struct packed {
    logic [COUNT_W-1:0] horizontal;
    logic [COUNT_W-1:0] vertical;
    logic [COUNT_W-1:0] diagonal;
    logic [COUNT_W-1:0] antidiagonal;
  } count_set_t;

  // Status from the length unit to the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } lu_status_t;

  function automatic logic opposite(input logic [1:0] a, input logic [1:0] b);
    return (a == SIGN_POS && b == SIGN_NEG) || (a == SIGN_NEG && b == SIGN_POS);
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] cnt,
                                                 input logic hit);
    return (hit && cnt != {COUNT_W{1'b1}}) ? cnt + COUNT_W'(1) : cnt;
  endfunction

endpackage

FILE: rtl/core/interface_length_crossing_counter_core.sv
// Interface length crossing counter: usage
// Samples of an N by N field arrive in raster order on the s_axis channel,
// one signed sample per item. Sign changes between strictly positive and
// strictly negative neighbours are counted horizontally, vertically and along
// both diagonals. After the last sample of a frame one result item leaves on
// m_axis with the four counts and the interface length in Q.16.
// Throughput: one sample per cycle. The input stalls only on the last sample
// of a frame while the previous result is still held or still being computed.
// After the last sample is accepted, the result passes through the length unit
// (capture, two setup steps, four multiply/add rounds and the done step) and
// then the output register.
// The result stays in an output register until taken; the next frame streams
// in meanwhile. Registers (APB): grid_size at 0x0, grid_spacing_q16 at 0x4.
// Writing grid_size abandons the frame in progress.
// Reset clears counters, indices and the pending result and restores the
// register defaults (N = 256, dx = 1.0); the row memory needs no clearing.
// Depends on ilcc_pkg, ilcc_scan, ilcc_length and ilcc_ram.
module interface_length_crossing_counter_core #(
  parameter int unsigned MAX_SIDE    = ilcc_pkg::DEF_MAX_SIDE,
  parameter int unsigned SAMPLE_BITS = ilcc_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [SAMPLE_BITS-1:0] sample, zero-filled to whole bytes
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [19:0] horizontal_crossings, [39:20] vertical_crossings,
  // [59:40] diagonal_crossings, [79:60] antidiagonal_crossings,
  // [123:80] length_q16, [127:124] zero
  output logic [ilcc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import ilcc_pkg::*;

  logic [SIZE_W-1:0]    grid_size_q;
  logic [SPACING_W-1:0] grid_spacing_q;
  logic                 cfg_wr, size_wr, is_last, frame_done, accept;
  count_set_t           scan_counts, lu_counts;
  lu_status_t           lu_status;
  logic [LEN_W-1:0]     lu_length;
  logic                 out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  reg_idx_e             reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign size_wr = cfg_wr && (reg_idx == REG_GRID_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q    <= GRID_SIZE_RST;
      grid_spacing_q <= GRID_SPACING_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_GRID_SIZE:    grid_size_q    <= pwdata[SIZE_W-1:0];
        REG_GRID_SPACING: grid_spacing_q <= pwdata[SPACING_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GRID_SIZE:    prdata = 32'(grid_size_q);
      REG_GRID_SPACING: prdata = 32'(grid_spacing_q);
      default:          prdata = '0;
    endcase
  end

  // The last sample of a frame waits until the length unit and the output
  // register are both free.
  assign s_axis_tready = !(is_last && (lu_status.busy || out_valid_q));
  assign accept        = s_axis_tvalid && s_axis_tready;

  ilcc_scan #(
    .MAX_SIDE    (MAX_SIDE),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .grid_size_i   (grid_size_q),
    .frame_clear_i (size_wr),
    .accept_i      (accept),
    .sample_i      (s_axis_tdata[SAMPLE_BITS-1:0]),
    .is_last_o     (is_last),
    .frame_done_o  (frame_done),
    .counts_o      (scan_counts)
  );

  ilcc_length u_length (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (frame_done),
    .counts_i  (scan_counts),
    .spacing_i (grid_spacing_q),
    .status_o  (lu_status),
    .counts_o  (lu_counts),
    .length_o  (lu_length)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (lu_status.done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lu_status.done) begin
      out_data_q <= {4'b0000, lu_length, lu_counts.antidiagonal, lu_counts.diagonal,
                     lu_counts.vertical, lu_counts.horizontal};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: rtl/core/ilcc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ilcc_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/ilcc_scan.sv
// Raster scan unit: sign classification, neighbour tracking and crossing counters.
// Keeps the row above in ilcc_ram; depends on ilcc_pkg.
module ilcc_scan #(
  parameter int unsigned MAX_SIDE    = ilcc_pkg::DEF_MAX_SIDE,
  parameter int unsigned SAMPLE_BITS = ilcc_pkg::DEF_SAMPLE_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [ilcc_pkg::SIZE_W-1:0]  grid_size_i,
  input  logic                         frame_clear_i,
  input  logic                         accept_i,
  input  logic [SAMPLE_BITS-1:0]       sample_i,
  output logic                         is_last_o,
  output logic                         frame_done_o,
  output ilcc_pkg::count_set_t         counts_o
);
  import ilcc_pkg::*;

  localparam int unsigned CW = $clog2(MAX_SIDE);
  localparam int unsigned NW = $clog2(MAX_SIDE + 1);

  logic [NW-1:0] side;
  logic [CW-1:0] col_q, col_d, row_q, row_d;
  logic [NW-1:0] col_next, row_next;
  logic          row_end, col_first;
  logic [1:0]    code, rdata, nb;
  sign_e         left_q, al_q, a_q, ovr_q, first0_q, first1_q;
  logic          use_ovr_q;
  count_set_t    cnt_q, cnt_d;

  always_comb begin
    if (32'(grid_size_i) < 32'd2) begin
      side = NW'(2);
    end else if (32'(grid_size_i) > 32'(MAX_SIDE)) begin
      side = NW'(MAX_SIDE);
    end else begin
      side = NW'(grid_size_i);
    end
  end

  assign code = sample_i[SAMPLE_BITS-1] ? SIGN_NEG :
                (sample_i != '0)        ? SIGN_POS : SIGN_ZERO;

  assign col_next  = NW'(col_q) + NW'(1);
  assign row_next  = NW'(row_q) + NW'(1);
  assign row_end   = col_next >= side;
  assign col_first = col_q == '0;
  assign is_last_o = row_end && (row_next >= side);
  assign frame_done_o = accept_i && is_last_o;

  // The right-above neighbour comes from the memory, except for the first
  // item of a row, whose value was kept in a register at the previous row end.
  assign nb = use_ovr_q ? ovr_q : rdata;

  // Write the current column while fetching two columns ahead, so the
  // read data lines up with the next item.
  ilcc_ram #(
    .WIDTH (2),
    .DEPTH (MAX_SIDE)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (accept_i),
    .waddr_i (col_q),
    .wdata_i (code),
    .re_i    (accept_i),
    .raddr_i (CW'(32'(col_q) + 32'd2)),
    .rdata_o (rdata)
  );

  always_comb begin
    cnt_d = cnt_q;
    cnt_d.horizontal = sat_inc(cnt_q.horizontal, !col_first && opposite(code, left_q));
    if (row_q != '0) begin
      cnt_d.vertical = sat_inc(cnt_q.vertical, opposite(code, a_q));
      cnt_d.diagonal = sat_inc(cnt_q.diagonal, !col_first && opposite(code, al_q));
      cnt_d.antidiagonal = sat_inc(cnt_q.antidiagonal, !row_end && opposite(code, nb));
    end
    col_d = row_end ? '0 : CW'(col_next);
    row_d = row_end ? (is_last_o ? '0 : CW'(row_next)) : row_q;
  end

  assign counts_o = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      cnt_q     <= '0;
      left_q    <= SIGN_ZERO;
      al_q      <= SIGN_ZERO;
      use_ovr_q <= 1'b0;
    end else if (frame_clear_i) begin
      col_q     <= '0;
      row_q     <= '0;
      cnt_q     <= '0;
      left_q    <= SIGN_ZERO;
      al_q      <= SIGN_ZERO;
      use_ovr_q <= 1'b0;
    end else if (accept_i) begin
      col_q     <= col_d;
      row_q     <= row_d;
      cnt_q     <= is_last_o ? '0 : cnt_d;
      left_q    <= sign_e'(code);
      al_q      <= a_q;
      use_ovr_q <= row_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      if (col_first) begin
        first0_q <= sign_e'(code);
      end
      if (col_q == CW'(1)) begin
        first1_q <= sign_e'(code);
      end
      if (row_end) begin
        a_q   <= first0_q;
        ovr_q <= (col_q == CW'(1)) ? sign_e'(code) : first1_q;
      end else begin
        a_q   <= sign_e'(nb);
      end
    end
  end

endmodule

FILE: rtl/core/ilcc_length.sv
// Length unit: (pi/8)*dx*(H+V+sqrt2*(D+A)) in Q.16 over a short multi-cycle sequence.
// The wide product is built from four 27x18 partial products; depends on ilcc_pkg.
module ilcc_length (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  ilcc_pkg::count_set_t           counts_i,
  input  logic [ilcc_pkg::SPACING_W-1:0] spacing_i,
  output ilcc_pkg::lu_status_t           status_o,
  output ilcc_pkg::count_set_t           counts_o,
  output logic [ilcc_pkg::LEN_W-1:0]     length_o
);
  import ilcc_pkg::*;

  lu_state_e state_q, state_d;
  count_set_t cnt_q;
  logic [SUM_W-1:0]     hv_q, da_q;
  logic [SPACING_W-1:0] dx_q;
  logic [T_W-1:0]       prod_da_q, t_q;
  logic [KPROD_W-1:0]   prod_k_q;
  logic [K_W-1:0]       k_q;
  logic [PP_W-1:0]      pp_q;
  logic [ACC_W-1:0]     acc_q, rounded;
  logic [1:0]           idx_q;
  logic [T_LO_W-1:0]    t_part;
  logic [K_LO_W-1:0]    k_part;
  logic [6:0]           pp_shift;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      LU_IDLE: if (start_i) state_d = LU_PREP;
      LU_PREP: state_d = LU_SUM;
      LU_SUM:  state_d = LU_MUL;
      LU_MUL:  state_d = LU_ADD;
      LU_ADD:  state_d = (idx_q == 2'd3) ? LU_DONE : LU_MUL;
      LU_DONE: state_d = LU_IDLE;
      default: state_d = LU_IDLE;
    endcase
  end

  always_comb begin
    status_o.busy = state_q != LU_IDLE;
    status_o.done = state_q == LU_DONE;
  end

  // Bit 1 of the index picks the T half, bit 0 the K half.
  assign t_part = idx_q[1] ? T_LO_W'(t_q[T_W-1:T_LO_W]) : t_q[T_LO_W-1:0];
  assign k_part = idx_q[0] ? K_LO_W'(k_q[K_W-1:K_LO_W]) : k_q[K_LO_W-1:0];
  assign pp_shift = (idx_q[1] ? 7'(T_LO_W) : 7'd0) + (idx_q[0] ? 7'(K_LO_W) : 7'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LU_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      LU_IDLE: begin
        if (start_i) begin
          cnt_q <= counts_i;
          hv_q  <= SUM_W'(counts_i.horizontal) + SUM_W'(counts_i.vertical);
          da_q  <= SUM_W'(counts_i.diagonal) + SUM_W'(counts_i.antidiagonal);
          dx_q  <= spacing_i;
        end
      end
      LU_PREP: begin
        prod_da_q <= T_W'(SQRT2_Q30 * T_W'(da_q));
        prod_k_q  <= KPROD_W'(PI8_Q32) * KPROD_W'(dx_q);
      end
      LU_SUM: begin
        t_q   <= {2'b00, hv_q, 30'd0} + prod_da_q;
        k_q   <= K_W'((prod_k_q + KPROD_W'(32768)) >> K_SHIFT);
        acc_q <= '0;
        idx_q <= 2'd0;
      end
      LU_MUL: begin
        pp_q <= PP_W'(t_part) * PP_W'(k_part);
      end
      LU_ADD: begin
        acc_q <= acc_q + (ACC_W'(pp_q) << pp_shift);
        idx_q <= idx_q + 2'd1;
      end
      default: ;
    endcase
  end

  // The product stays below 2^89, so the rounded length always fits 44 bits.
  assign rounded  = acc_q + (ACC_W'(1) << (LEN_SHIFT - 1));
  assign length_o = rounded[LEN_SHIFT +: LEN_W];
  assign counts_o = cnt_q;

endmodule

FILE: rtl/core/ilcc_checker.sv
// Port-level checker for the interface length crossing counter, bound to the top level.
// Depends on ilcc_pkg.
module ilcc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [ilcc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic                             psel,
  input logic                             penable,
  input logic                             pwrite,
  input logic [2:0]                       paddr,
  input logic [31:0]                      pwdata,
  input logic [31:0]                      prdata,
  input logic                             pready
);
  import ilcc_pkg::*;

  // A held result keeps its data until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // One result per frame, and a frame is at least four items long.
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
    else $error("second result directly after a taken one");

  // A written grid size reads back.
  a_size_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr[2] == REG_GRID_SIZE |=>
      paddr[2] != REG_GRID_SIZE || prdata[SIZE_W-1:0] == $past(pwdata[SIZE_W-1:0]))
    else $error("grid size readback mismatch");

  // The padding bits of the result item are always zero.
  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:COUNT_W*4+LEN_W] == '0)
    else $error("result padding not zero");

endmodule

bind interface_length_crossing_counter_core ilcc_checker u_ilcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready)
);
